// ===== sv/hcbd_pkg.sv =====
// shared types, constants and helpers for the chunked body decoder
// no dependencies; every other file in sv imports this package
package hcbd_pkg;

   localparam int SIZE_BITS = 32;
   localparam int LIMIT_W   = 32;
   localparam int CMP_W     = (SIZE_BITS > LIMIT_W) ? SIZE_BITS : LIMIT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048576);

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   typedef enum logic [2:0] {
      PH_SIZE = 3'd0,
      PH_EXT  = 3'd1,
      PH_LF   = 3'd2,
      PH_DATA = 3'd3,
      PH_SKIP = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_END    = 2'd1,
      KIND_FORMAT = 2'd2,
      KIND_LARGE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_of_body;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] body_byte;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_value(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== sv/hcbd_stream_if.sv =====
// valid/ready channel interfaces for requests and responses
// depends on hcbd_pkg for the payload types
interface hcbd_req_if;
   import hcbd_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hcbd_rsp_if;
   import hcbd_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/hcbd_core.sv =====
// decode state and per-byte next-state and result logic
// depends on hcbd_pkg
module hcbd_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  hcbd_pkg::req_type             item,
   input  logic [hcbd_pkg::LIMIT_W-1:0]  body_limit,
   output hcbd_pkg::result_type          result
);
   import hcbd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [SIZE_BITS-1:0]  chunk_ff, chunk_in;
   logic [LIMIT_W-1:0]    budget_ff, budget_in;
   logic                  digit_ff, digit_in;
   logic                  skip_ff, skip_in;

   phase_type             cur_phase;
   logic [SIZE_BITS-1:0]  cur_chunk;
   logic [LIMIT_W-1:0]    cur_budget;
   logic                  cur_digit;
   logic                  cur_skip;
   hex_type               hex;
   logic [CMP_W-1:0]      chunk_wide;
   logic [CMP_W-1:0]      budget_wide;
   logic [SIZE_BITS-1:0]  chunk_dec;

   // first byte of a body restarts the decode
   always_comb begin
      if (item.first_of_body) begin
         cur_phase  = PH_SIZE;
         cur_chunk  = '0;
         cur_budget = body_limit;
         cur_digit  = 1'b0;
         cur_skip   = 1'b0;
      end else begin
         cur_phase  = phase_ff;
         cur_chunk  = chunk_ff;
         cur_budget = budget_ff;
         cur_digit  = digit_ff;
         cur_skip   = skip_ff;
      end
   end

   assign hex         = hex_value(item.in_byte);
   assign chunk_wide  = CMP_W'(cur_chunk);
   assign budget_wide = CMP_W'(cur_budget);
   assign chunk_dec   = cur_chunk - SIZE_BITS'(1);

   // next state
   always_comb begin
      phase_in  = cur_phase;
      chunk_in  = cur_chunk;
      budget_in = cur_budget;
      digit_in  = cur_digit;
      skip_in   = cur_skip;
      case (cur_phase)
         PH_SIZE: begin
            if (hex.ok) begin
               if (cur_chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
                  phase_in = PH_DONE;
               end else begin
                  chunk_in = {cur_chunk[SIZE_BITS-5:0], hex.value};
                  digit_in = 1'b1;
               end
            end else if (item.in_byte == CHAR_SEMI) begin
               phase_in = PH_EXT;
            end else if (item.in_byte == CHAR_CR) begin
               phase_in = PH_LF;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_EXT: begin
            if (item.in_byte == CHAR_CR) begin
               phase_in = PH_LF;
            end
         end
         PH_LF: begin
            if (item.in_byte != CHAR_LF || !cur_digit) begin
               phase_in = PH_DONE;
            end else if (cur_chunk == '0) begin
               phase_in = PH_DONE;
            end else if (chunk_wide > budget_wide) begin
               phase_in = PH_DONE;
            end else begin
               budget_in = LIMIT_W'(budget_wide - chunk_wide);
               phase_in  = PH_DATA;
            end
         end
         PH_DATA: begin
            chunk_in = chunk_dec;
            if (chunk_dec == '0) begin
               phase_in = PH_SKIP;
               skip_in  = 1'b0;
            end
         end
         PH_SKIP: begin
            if (!cur_skip) begin
               skip_in = 1'b1;
            end else begin
               phase_in = PH_SIZE;
               chunk_in = '0;
               digit_in = 1'b0;
               skip_in  = 1'b0;
            end
         end
         default: begin
            phase_in = cur_phase;
         end
      endcase
   end

   // result
   always_comb begin
      result.valid          = 1'b0;
      result.data.kind      = KIND_BYTE;
      result.data.body_byte = 8'd0;
      case (cur_phase)
         PH_SIZE: begin
            if (hex.ok) begin
               if (cur_chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
                  result.valid     = 1'b1;
                  result.data.kind = KIND_LARGE;
               end
            end else if (item.in_byte != CHAR_SEMI && item.in_byte != CHAR_CR) begin
               result.valid     = 1'b1;
               result.data.kind = KIND_FORMAT;
            end
         end
         PH_LF: begin
            if (item.in_byte != CHAR_LF || !cur_digit) begin
               result.valid     = 1'b1;
               result.data.kind = KIND_FORMAT;
            end else if (cur_chunk == '0) begin
               result.valid     = 1'b1;
               result.data.kind = KIND_END;
            end else if (chunk_wide > budget_wide) begin
               result.valid     = 1'b1;
               result.data.kind = KIND_LARGE;
            end
         end
         PH_DATA: begin
            result.valid          = 1'b1;
            result.data.kind      = KIND_BYTE;
            result.data.body_byte = item.in_byte;
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIZE;
         chunk_ff  <= '0;
         budget_ff <= '0;
         digit_ff  <= 1'b0;
         skip_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         chunk_ff  <= chunk_in;
         budget_ff <= budget_in;
         digit_ff  <= digit_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

// ===== sv/http_chunked_body_decoder.sv =====
// Chunked body decoder: one request carries one raw byte of an HTTP chunked body;
// each byte yields at most one response (payload byte, end of body, bad format or
// too large). A request is accepted every cycle unless the input register is full
// and the output register is stalled: the byte sits in an input register, the hex
// accumulate, budget compare and data countdown run in one pass of logic, and the
// response lands in an output register that may stall while the next request is taken.
// body_limit is loaded into the budget on each request with first_of_body set.
// depends on hcbd_pkg, hcbd_stream_if and hcbd_core
module http_chunked_body_decoder (
   input  logic                          clock,
   input  logic                          reset,
   hcbd_req_if.sink                      req_chan,
   hcbd_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [hcbd_pkg::LIMIT_W-1:0]  csr_wdata
);
   import hcbd_pkg::*;

   logic               in_valid_ff, in_valid_in;
   req_type            in_item_ff, in_item_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_item_ff, out_item_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               advance;
   logic               req_take;
   result_type         result;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   hcbd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .body_limit (limit_ff),
      .result     (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_chan.payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = result.valid;
         out_item_in  = result.data;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign limit_in = csr_we ? csr_wdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted request not held in input register");

   a_no_byte_on_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.kind != KIND_BYTE) |->
      (rsp_chan.payload.body_byte == 8'd0))
      else $error("status response carries a payload byte");

   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance))
      else $error("response appeared without a request");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while pipeline stalled");

endmodule
